@@ rtl/cfb_pkg.sv @@
// Shared types, constants and codes for the clipped framebuffer fill block.
package cfb_pkg;

  // Store geometry and field widths.
  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned XBITS       = $clog2(MAX_WIDTH);
  localparam int unsigned YBITS       = $clog2(MAX_HEIGHT);
  localparam int unsigned DIM_BITS    = 9;
  localparam int unsigned ADDR_BITS   = XBITS + YBITS;
  localparam int unsigned DEPTH       = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned COLOUR_BITS = 24;
  localparam int unsigned COUNT_BITS  = 17;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 12;

  // Item modes.
  localparam logic [1:0] MODE_PLOT = 2'd0;
  localparam logic [1:0] MODE_READ = 2'd1;
  localparam logic [1:0] MODE_FILL = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEFT      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_TOP       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_SPAN_X    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_SPAN_Y    = 3'd5;

  typedef struct packed {
    logic [1:0]             mode;
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [COORD_BITS-1:0]  box_width;
    logic [COORD_BITS-1:0]  box_height;
    logic [COLOUR_BITS-1:0] colour_in;
  } in_t;

  typedef struct packed {
    logic [COLOUR_BITS-1:0] read_colour;
    logic [COUNT_BITS-1:0]  pixels_written;
  } out_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]   surface_width;
    logic [DIM_BITS-1:0]   surface_height;
    logic [COORD_BITS-1:0] clip_left;
    logic [COORD_BITS-1:0] clip_top;
    logic [COORD_BITS-1:0] clip_span_x;
    logic [COORD_BITS-1:0] clip_span_y;
  } cfg_t;

  // Pixel store access issued by the sequencer.
  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [ADDR_BITS-1:0]   addr;
    logic [COLOUR_BITS-1:0] wdata;
  } mem_req_t;

endpackage

@@ rtl/cfb_regs.sv @@
// Configuration register file of the clipped framebuffer fill block.
module cfb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cfb_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [cfb_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  output cfb_pkg::cfg_t                      cfg_o
);
  import cfb_pkg::*;

  cfg_t cfg_q, cfg_d;

  // A write is always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SURFACE_WIDTH:  cfg_d.surface_width  = cfg_data_i[DIM_BITS-1:0];
        REG_SURFACE_HEIGHT: cfg_d.surface_height = cfg_data_i[DIM_BITS-1:0];
        REG_CLIP_LEFT:      cfg_d.clip_left      = cfg_data_i[COORD_BITS-1:0];
        REG_CLIP_TOP:       cfg_d.clip_top       = cfg_data_i[COORD_BITS-1:0];
        REG_CLIP_SPAN_X:    cfg_d.clip_span_x    = cfg_data_i[COORD_BITS-1:0];
        REG_CLIP_SPAN_Y:    cfg_d.clip_span_y    = cfg_data_i[COORD_BITS-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/cfb_mem.sv @@
// Pixel store: single-port memory with a registered read word.
module cfb_mem (
  input  logic                               clk_i,
  input  cfb_pkg::mem_req_t                  req_i,
  output logic [cfb_pkg::COLOUR_BITS-1:0]    rdata_o
);
  import cfb_pkg::*;

  logic [COLOUR_BITS-1:0] store_q [DEPTH];
  logic [COLOUR_BITS-1:0] rdata_q;

  // One write or one read per cycle; the read word holds until the next read.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      store_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= store_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/cfb_seq.sv @@
// Sequencer: clips an item, then walks its pixels through one address unit.
module cfb_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cfb_pkg::cfg_t                    cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  cfb_pkg::in_t                     in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output cfb_pkg::out_t                    out_o,
  output cfb_pkg::mem_req_t                mem_req_o,
  input  logic [cfb_pkg::COLOUR_BITS-1:0]  mem_rdata_i
);
  import cfb_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CLIP = 3'd1;
  localparam logic [2:0] ST_BASE = 3'd2;
  localparam logic [2:0] ST_FILL = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  localparam int unsigned EW = COORD_BITS + 1;

  logic [2:0]           state_q, state_d;
  in_t                  item_q, item_d;
  logic [1:0]           act_q, act_d;
  logic [XBITS-1:0]     cx_q, cx_d, x0_q, x0_d;
  logic [YBITS-1:0]     cy_q, cy_d;
  logic [XBITS:0]       x1_q, x1_d;
  logic [YBITS:0]       y1_q, y1_d;
  logic [ADDR_BITS-1:0] row_q, row_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  out_t                 out_q, out_d;

  logic [DIM_BITS-1:0]   w_eff, h_eff;
  logic [COORD_BITS-1:0] bw_eff, bh_eff, x0c, y0c;
  logic [EW-1:0]         x_end, y_end, cx_end, cy_end, x1c, y1c, x1t, y1t;
  logic                  surf_ok, box_empty, rd_ok;
  logic [ADDR_BITS-1:0]  addr;
  logic [DIM_BITS+YBITS-1:0] base_prod;
  logic                  last_x, last_y;

  // Surface size saturated to the store geometry.
  always_comb begin
    w_eff = (cfg_i.surface_width > DIM_BITS'(MAX_WIDTH)) ?
            DIM_BITS'(MAX_WIDTH) : cfg_i.surface_width;
    h_eff = (cfg_i.surface_height > DIM_BITS'(MAX_HEIGHT)) ?
            DIM_BITS'(MAX_HEIGHT) : cfg_i.surface_height;
  end

  // Clip bounds: intersection of box, clip rectangle and surface, no wrap.
  always_comb begin
    bw_eff  = (item_q.mode == MODE_FILL) ? item_q.box_width  : COORD_BITS'(1);
    bh_eff  = (item_q.mode == MODE_FILL) ? item_q.box_height : COORD_BITS'(1);
    x_end   = EW'(item_q.pos_x) + EW'(bw_eff);
    y_end   = EW'(item_q.pos_y) + EW'(bh_eff);
    cx_end  = EW'(cfg_i.clip_left) + EW'(cfg_i.clip_span_x);
    cy_end  = EW'(cfg_i.clip_top) + EW'(cfg_i.clip_span_y);
    x0c     = (item_q.pos_x > cfg_i.clip_left) ? item_q.pos_x : cfg_i.clip_left;
    y0c     = (item_q.pos_y > cfg_i.clip_top)  ? item_q.pos_y : cfg_i.clip_top;
    x1t     = (x_end < cx_end) ? x_end : cx_end;
    y1t     = (y_end < cy_end) ? y_end : cy_end;
    x1c     = (x1t < EW'(w_eff)) ? x1t : EW'(w_eff);
    y1c     = (y1t < EW'(h_eff)) ? y1t : EW'(h_eff);
    surf_ok = (w_eff != '0) && (h_eff != '0);
    box_empty = !surf_ok || (EW'(x0c) >= x1c) || (EW'(y0c) >= y1c);
    rd_ok   = surf_ok && (item_q.pos_x < COORD_BITS'(w_eff)) &&
              (item_q.pos_y < COORD_BITS'(h_eff));
  end

  // Shared address unit and row-start multiplier.
  assign addr      = row_q + ADDR_BITS'(cx_q);
  assign base_prod = cy_q * w_eff;
  assign last_x    = ((XBITS+1)'(cx_q) + (XBITS+1)'(1)) == x1_q;
  assign last_y    = ((YBITS+1)'(cy_q) + (YBITS+1)'(1)) == y1_q;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    act_d       = act_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    x0_d        = x0_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    in_ready_o  = 1'b0;
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.addr  = addr;
    mem_req_o.wdata = item_q.colour_in;

    // The receiver drains the result register.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d  = in_i;
          cnt_d   = '0;
          state_d = ST_CLIP;
        end
      end
      ST_CLIP: begin
        if (item_q.mode == MODE_READ) begin
          act_d = rd_ok ? ACT_READ : ACT_NONE;
          cx_d  = item_q.pos_x[XBITS-1:0];
          cy_d  = item_q.pos_y[YBITS-1:0];
        end else if ((item_q.mode == MODE_PLOT || item_q.mode == MODE_FILL) &&
                     !box_empty) begin
          act_d = ACT_WRITE;
          cx_d  = x0c[XBITS-1:0];
          cy_d  = y0c[YBITS-1:0];
        end else begin
          act_d = ACT_NONE;
        end
        x0_d    = x0c[XBITS-1:0];
        x1_d    = x1c[XBITS:0];
        y1_d    = y1c[YBITS:0];
        state_d = ST_BASE;
      end
      ST_BASE: begin
        row_d = base_prod[ADDR_BITS-1:0];
        unique case (act_q)
          ACT_WRITE: state_d = ST_FILL;
          ACT_READ:  state_d = ST_READ;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_FILL: begin
        // One pixel a cycle, row by row.
        mem_req_o.we = 1'b1;
        cnt_d = cnt_q + COUNT_BITS'(1);
        if (last_x) begin
          cx_d  = x0_q;
          row_d = row_q + ADDR_BITS'(w_eff);
          if (last_y) begin
            state_d = ST_DONE;
          end else begin
            cy_d = cy_q + YBITS'(1);
          end
        end else begin
          cx_d = cx_q + XBITS'(1);
        end
      end
      ST_READ: begin
        mem_req_o.re = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Load the result once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_d.read_colour    = (act_q == ACT_READ) ? mem_rdata_i : '0;
          out_d.pixels_written = cnt_q;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    act_q  <= act_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    x0_q   <= x0_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    row_q  <= row_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ rtl/clipped_framebuffer_fill.sv @@
// Top level of the clipped framebuffer fill block.
//
// Items arrive on in_valid_i/in_ready_o as one in_t word: plot (mode 0),
// read (mode 1) or rectangle fill (mode 2). Each item gives one out_t word
// on out_valid_o/out_ready_i. The user must write registers through
// cfg_valid_i, cfg_index_i and cfg_data_i only while no item is in flight;
// the block itself does not enforce this. cfg_ready_o is always high. An item
// runs in the sequencer: clip, row-start multiply, then one pixel per cycle
// through the single store port. The store port, one pixel a cycle, sets the
// fill rate. A new item is accepted in the cycle after the result is loaded,
// even if that result still waits for the receiver; a stalled receiver holds
// the sequencer only when the next result is ready.
// Reset clears the registers and the control state; the pixel store is not
// cleared and holds unknown data until written.
module clipped_framebuffer_fill (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cfb_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [cfb_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  cfb_pkg::in_t                       in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output cfb_pkg::out_t                      out_o
);
  import cfb_pkg::*;

  cfg_t                   cfg;
  mem_req_t               mem_req;
  logic [COLOUR_BITS-1:0] mem_rdata;

  cfb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cfb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  cfb_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // The store is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("pixel store read and written together");

  // No item is taken while pixels are still being written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we || mem_req.re) |-> !in_ready_o)
    else $error("item accepted during store access");

  // A result either carries a colour or a pixel count, never both.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.read_colour == '0 || out_o.pixels_written == '0))
    else $error("result has both colour and count");

  // The count cannot exceed the store size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.pixels_written <= COUNT_BITS'(DEPTH)))
    else $error("pixel count beyond store size");

endmodule
